// ----- hdl/cb0ie_pkg.sv -----
// shared types and codes for the block-zero instruction execute unit
package cb0ie_pkg;

	typedef logic [5:0]  cmd_t;
	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;
	typedef logic [3:0]  flag_t;
	typedef logic [1:0]  wkind_t;

	// memory write kinds
	localparam wkind_t WK_NONE = 2'd0;
	localparam wkind_t WK_ONE  = 2'd1;
	localparam wkind_t WK_TWO  = 2'd2;

	// flag nibble bit positions
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

endpackage

// ----- hdl/cb0ie_if.sv -----
// valid/ready channel interfaces for instruction requests and results
interface cb0ie_in_if;
	import cb0ie_pkg::*;

	logic  valid;
	logic  ready;
	cmd_t  cmd;
	word_t immediate;
	byte_t mem_in;

	modport source (output valid, output cmd, output immediate, output mem_in, input ready);
	modport sink (input valid, input cmd, input immediate, input mem_in, output ready);
endinterface

interface cb0ie_out_if;
	import cb0ie_pkg::*;

	logic   valid;
	logic   ready;
	byte_t  acc;
	flag_t  flags;
	word_t  pair_bc;
	word_t  pair_de;
	word_t  pair_hl;
	word_t  stack_ptr;
	word_t  prog_ctr;
	wkind_t write_kind;
	word_t  write_addr;
	word_t  write_data;

	modport source (
		output valid, output acc, output flags, output pair_bc, output pair_de,
		output pair_hl, output stack_ptr, output prog_ctr, output write_kind,
		output write_addr, output write_data, input ready
	);
	modport sink (
		input valid, input acc, input flags, input pair_bc, input pair_de,
		input pair_hl, input stack_ptr, input prog_ctr, input write_kind,
		input write_addr, input write_data, output ready
	);
endinterface

// ----- hdl/cpu_block0_instruction_execute.sv -----
// block-zero (opcodes 0x00..0x3f) instruction execute unit with register file
// an accepted request is registered in stage 1, its result in stage 2 and the register file;
// throughput: one request per cycle unless results stall; the input register takes
// a new request while the result register waits; all opcode decode and alu sit between them
// reset (arst_n low, asynchronous): A, flags, BC, DE, HL, SP and PC clear to zero and
// both pipeline stages empty
module cpu_block0_instruction_execute (
	input logic          clk,
	input logic          arst_n,
	cb0ie_in_if.sink     instr,
	cb0ie_out_if.source  result
);
	import cb0ie_pkg::*;

	// 8-bit operand codes that need special handling
	localparam logic [2:0] R8_MEM = 3'd6;
	localparam logic [2:0] R8_A   = 3'd7;
	// pair codes
	localparam logic [1:0] PR_BC = 2'd0;
	localparam logic [1:0] PR_DE = 2'd1;
	localparam logic [1:0] PR_HL = 2'd2;
	localparam logic [1:0] PR_SP = 2'd3;
	// decimal adjust constants
	localparam byte_t DAA_HI = 8'h60;
	localparam byte_t DAA_LO = 8'h06;

	// stage 1: registered request
	logic  v_s1;
	cmd_t  cmd_s1;
	word_t imm_s1;
	byte_t mem_s1;

	// stage 2: result valid and memory write; the register file itself is the
	// rest of the result, since it only moves when a result is loaded
	logic   v_s2;
	wkind_t wk_s2;
	word_t  wa_s2;
	word_t  wd_s2;

	// architectural registers
	byte_t acc_q;
	flag_t flag_q;
	word_t bc_q;
	word_t de_q;
	word_t hl_q;
	word_t sp_q;
	word_t pc_q;

	logic in_acc;
	logic advance;

	// decode
	logic [2:0] row;
	logic [2:0] col;
	byte_t      imm8;
	word_t      jr_off;
	word_t      pc_seq2;
	word_t      pair_rd;
	byte_t      r8_rd;
	word_t      ld_addr;

	// execute
	byte_t  nv;
	byte_t  daa_a;
	logic   daa_c;
	logic   take;
	logic [16:0] add_sum;
	logic [12:0] add_half;
	flag_t  f;
	word_t  n_pc;
	wkind_t wk;
	word_t  wa;
	word_t  wd;

	// register file write ports
	logic       r8_we;
	logic [2:0] r8_idx;
	byte_t      r8_val;
	logic       pr_we;
	logic [1:0] pr_idx;
	word_t      pr_val;

	byte_t n_acc;
	word_t n_bc;
	word_t n_de;
	word_t n_hl;
	word_t n_sp;

	// handshake: stage 1 drains whenever the result register is free or being taken
	assign advance     = v_s1 && (!v_s2 || result.ready);
	assign instr.ready = !v_s1 || !v_s2 || result.ready;
	assign in_acc      = instr.valid && instr.ready;

	assign row     = cmd_s1[5:3];
	assign col     = cmd_s1[2:0];
	assign imm8    = imm_s1[7:0];
	assign jr_off  = {{8{imm8[7]}}, imm8};
	assign pc_seq2 = pc_q + 16'd2;

	// pair named by row[2:1]
	always_comb begin
		case (row[2:1])
			PR_BC:   pair_rd = bc_q;
			PR_DE:   pair_rd = de_q;
			PR_HL:   pair_rd = hl_q;
			default: pair_rd = sp_q;
		endcase
	end

	// 8-bit operand named by row; [hl] comes from the memory byte
	always_comb begin
		case (row)
			3'd0:    r8_rd = bc_q[15:8];
			3'd1:    r8_rd = bc_q[7:0];
			3'd2:    r8_rd = de_q[15:8];
			3'd3:    r8_rd = de_q[7:0];
			3'd4:    r8_rd = hl_q[15:8];
			3'd5:    r8_rd = hl_q[7:0];
			R8_MEM:  r8_rd = mem_s1;
			default: r8_rd = acc_q;
		endcase
	end

	// indirect loads and stores address through bc, de, or hl (with hl+/hl-)
	always_comb begin
		case (row[2:1])
			PR_BC:   ld_addr = bc_q;
			PR_DE:   ld_addr = de_q;
			default: ld_addr = hl_q;
		endcase
	end

	assign add_sum  = {1'b0, hl_q} + {1'b0, pair_rd};
	assign add_half = {1'b0, hl_q[11:0]} + {1'b0, pair_rd[11:0]};

	// main decode and alu
	always_comb begin
		n_pc   = pc_q + 16'd1;
		f      = flag_q;
		wk     = WK_NONE;
		wa     = '0;
		wd     = '0;
		r8_we  = 1'b0;
		r8_idx = row;
		r8_val = '0;
		pr_we  = 1'b0;
		pr_idx = row[2:1];
		pr_val = '0;
		nv     = '0;
		daa_a  = acc_q;
		daa_c  = flag_q[FLAG_C];
		take   = 1'b0;

		case (col)
			3'd0: begin
				if (row == 3'd1) begin
					// ld [a16],sp: two bytes
					n_pc = pc_q + 16'd3;
					wk   = WK_TWO;
					wa   = imm_s1;
					wd   = sp_q;
				end else if (row == 3'd2) begin
					// stop: skip its operand byte
					n_pc = pc_seq2;
				end else if (row != 3'd0) begin
					// jr and its conditional forms
					case (row)
						3'd4:    take = !flag_q[FLAG_Z];
						3'd5:    take = flag_q[FLAG_Z];
						3'd6:    take = !flag_q[FLAG_C];
						3'd7:    take = flag_q[FLAG_C];
						default: take = 1'b1;
					endcase
					n_pc = take ? pc_seq2 + jr_off : pc_seq2;
				end
			end
			3'd1: begin
				if (!row[0]) begin
					// ld rr,d16
					n_pc   = pc_q + 16'd3;
					pr_we  = 1'b1;
					pr_val = imm_s1;
				end else begin
					// add hl,rr: half carry from bit 11, z kept
					pr_we          = 1'b1;
					pr_idx         = PR_HL;
					pr_val         = add_sum[15:0];
					f[FLAG_N]      = 1'b0;
					f[FLAG_H]      = add_half[12];
					f[FLAG_C]      = add_sum[16];
				end
			end
			3'd2: begin
				if (!row[0]) begin
					wk = WK_ONE;
					wa = ld_addr;
					wd = {8'h00, acc_q};
				end else begin
					r8_we  = 1'b1;
					r8_idx = R8_A;
					r8_val = mem_s1;
				end
				if (row[2:1] == PR_HL) begin
					pr_we  = 1'b1;
					pr_idx = PR_HL;
					pr_val = hl_q + 16'd1;
				end else if (row[2:1] == PR_SP) begin
					pr_we  = 1'b1;
					pr_idx = PR_HL;
					pr_val = hl_q - 16'd1;
				end
			end
			3'd3: begin
				pr_we  = 1'b1;
				pr_val = row[0] ? pair_rd - 16'd1 : pair_rd + 16'd1;
			end
			3'd4, 3'd5: begin
				// inc r / dec r, c kept
				if (col == 3'd4) begin
					nv        = r8_rd + 8'd1;
					f[FLAG_N] = 1'b0;
					f[FLAG_H] = (r8_rd[3:0] == 4'hf);
				end else begin
					nv        = r8_rd - 8'd1;
					f[FLAG_N] = 1'b1;
					f[FLAG_H] = (r8_rd[3:0] == 4'h0);
				end
				f[FLAG_Z] = (nv == 8'h00);
				if (row == R8_MEM) begin
					wk = WK_ONE;
					wa = hl_q;
					wd = {8'h00, nv};
				end else begin
					r8_we  = 1'b1;
					r8_val = nv;
				end
			end
			3'd6: begin
				// ld r,d8
				n_pc = pc_seq2;
				if (row == R8_MEM) begin
					wk = WK_ONE;
					wa = hl_q;
					wd = {8'h00, imm8};
				end else begin
					r8_we  = 1'b1;
					r8_val = imm8;
				end
			end
			default: begin
				r8_idx = R8_A;
				case (row)
					3'd0: begin
						r8_we  = 1'b1;
						r8_val = {acc_q[6:0], acc_q[7]};
						f      = {3'b000, acc_q[7]};
					end
					3'd1: begin
						r8_we  = 1'b1;
						r8_val = {acc_q[0], acc_q[7:1]};
						f      = {3'b000, acc_q[0]};
					end
					3'd2: begin
						r8_we  = 1'b1;
						r8_val = {acc_q[6:0], flag_q[FLAG_C]};
						f      = {3'b000, acc_q[7]};
					end
					3'd3: begin
						r8_we  = 1'b1;
						r8_val = {flag_q[FLAG_C], acc_q[7:1]};
						f      = {3'b000, acc_q[0]};
					end
					3'd4: begin
						// daa, direction set by n
						if (!flag_q[FLAG_N]) begin
							if (flag_q[FLAG_C] || acc_q > 8'h99) begin
								daa_a = acc_q + DAA_HI;
								daa_c = 1'b1;
							end
							if (flag_q[FLAG_H] || daa_a[3:0] > 4'd9) begin
								daa_a = daa_a + DAA_LO;
							end
						end else begin
							if (flag_q[FLAG_C]) begin
								daa_a = daa_a - DAA_HI;
							end
							if (flag_q[FLAG_H]) begin
								daa_a = daa_a - DAA_LO;
							end
						end
						r8_we  = 1'b1;
						r8_val = daa_a;
						f      = {(daa_a == 8'h00), flag_q[FLAG_N], 1'b0, daa_c};
					end
					3'd5: begin
						r8_we     = 1'b1;
						r8_val    = ~acc_q;
						f[FLAG_N] = 1'b1;
						f[FLAG_H] = 1'b1;
					end
					3'd6: begin
						f = {flag_q[FLAG_Z], 3'b001};
					end
					default: begin
						f = {flag_q[FLAG_Z], 2'b00, !flag_q[FLAG_C]};
					end
				endcase
			end
		endcase
	end

	// apply register file writes; pair first, then the 8-bit port
	always_comb begin
		n_acc = acc_q;
		n_bc  = bc_q;
		n_de  = de_q;
		n_hl  = hl_q;
		n_sp  = sp_q;
		if (pr_we) begin
			case (pr_idx)
				PR_BC:   n_bc = pr_val;
				PR_DE:   n_de = pr_val;
				PR_HL:   n_hl = pr_val;
				default: n_sp = pr_val;
			endcase
		end
		if (r8_we) begin
			case (r8_idx)
				3'd0:    n_bc[15:8] = r8_val;
				3'd1:    n_bc[7:0]  = r8_val;
				3'd2:    n_de[15:8] = r8_val;
				3'd3:    n_de[7:0]  = r8_val;
				3'd4:    n_hl[15:8] = r8_val;
				3'd5:    n_hl[7:0]  = r8_val;
				R8_A:    n_acc      = r8_val;
				default: n_acc      = acc_q;
			endcase
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			acc_q  <= '0;
			flag_q <= '0;
			bc_q   <= '0;
			de_q   <= '0;
			hl_q   <= '0;
			sp_q   <= '0;
			pc_q   <= '0;
		end else begin
			if (in_acc) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				v_s2 <= 1'b1;
			end else if (result.ready) begin
				v_s2 <= 1'b0;
			end
			if (advance) begin
				acc_q  <= n_acc;
				flag_q <= f;
				bc_q   <= n_bc;
				de_q   <= n_de;
				hl_q   <= n_hl;
				sp_q   <= n_sp;
				pc_q   <= n_pc;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_s1 <= instr.cmd;
			imm_s1 <= instr.immediate;
			mem_s1 <= instr.mem_in;
		end
		if (advance) begin
			wk_s2 <= wk;
			wa_s2 <= wa;
			wd_s2 <= wd;
		end
	end

	assign result.valid      = v_s2;
	assign result.acc        = acc_q;
	assign result.flags      = flag_q;
	assign result.pair_bc    = bc_q;
	assign result.pair_de    = de_q;
	assign result.pair_hl    = hl_q;
	assign result.stack_ptr  = sp_q;
	assign result.prog_ctr   = pc_q;
	assign result.write_kind = wk_s2;
	assign result.write_addr = wa_s2;
	assign result.write_data = wd_s2;

endmodule

// ----- hdl/cb0ie_checker.sv -----
// port-level checks for the block-zero execute unit, bound to the top level
module cb0ie_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input cb0ie_pkg::byte_t  acc,
	input cb0ie_pkg::word_t  prog_ctr,
	input cb0ie_pkg::wkind_t write_kind,
	input cb0ie_pkg::word_t  write_addr,
	input cb0ie_pkg::word_t  write_data
);
	import cb0ie_pkg::*;

	// a stalled result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its accumulator, program counter and write fields
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(acc) && $stable(prog_ctr)
			&& $stable(write_kind) && $stable(write_addr) && $stable(write_data))
		else $error("result payload changed while stalled");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> write_kind == WK_NONE || write_kind == WK_ONE || write_kind == WK_TWO)
		else $error("illegal write kind");

	// no write means address and data read as zero
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_kind == WK_NONE |-> write_addr == '0 && write_data == '0)
		else $error("stray write address or data");

	// single byte stores leave the upper data byte clear
	a_one_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_kind == WK_ONE |-> write_data[15:8] == 8'h00)
		else $error("single byte write carries upper data");

endmodule

bind cpu_block0_instruction_execute cb0ie_checker u_cb0ie_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.acc        (result.acc),
	.prog_ctr   (result.prog_ctr),
	.write_kind (result.write_kind),
	.write_addr (result.write_addr),
	.write_data (result.write_data)
);

// ----- dv/cb0ie_exec_checker.sv -----
// checker for the block-zero execute unit: register predictor and result scoreboard
module cb0ie_exec_checker (
	input  logic       clk,
	input  logic       arst_n,
	cb0ie_in_if        instr,
	cb0ie_out_if       result,
	output int         fail_count,
	output int         awaiting_results
);
	timeunit 1ns;
	timeprecision 1ps;

	import cb0ie_pkg::*;

	// opcode column (bits 2..0)
	localparam logic [2:0] COL_CTRL    = 3'd0;
	localparam logic [2:0] COL_PAIR16  = 3'd1;
	localparam logic [2:0] COL_LD_IND  = 3'd2;
	localparam logic [2:0] COL_INCDEC16 = 3'd3;
	localparam logic [2:0] COL_INC8    = 3'd4;
	localparam logic [2:0] COL_DEC8    = 3'd5;
	localparam logic [2:0] COL_LD8_IMM = 3'd6;
	localparam logic [2:0] COL_ACC_OPS = 3'd7;

	// opcode row (bits 5..3) within the control column
	localparam logic [2:0] ROW_NOP       = 3'd0;
	localparam logic [2:0] ROW_LD_A16_SP = 3'd1;
	localparam logic [2:0] ROW_STOP      = 3'd2;
	localparam logic [2:0] ROW_JR        = 3'd3;
	localparam logic [2:0] ROW_JR_NZ     = 3'd4;
	localparam logic [2:0] ROW_JR_Z      = 3'd5;
	localparam logic [2:0] ROW_JR_NC     = 3'd6;
	localparam logic [2:0] ROW_JR_C      = 3'd7;

	// opcode row within the accumulator column
	localparam logic [2:0] ROW_RLCA = 3'd0;
	localparam logic [2:0] ROW_RRCA = 3'd1;
	localparam logic [2:0] ROW_RLA  = 3'd2;
	localparam logic [2:0] ROW_RRA  = 3'd3;
	localparam logic [2:0] ROW_DAA  = 3'd4;
	localparam logic [2:0] ROW_CPL  = 3'd5;
	localparam logic [2:0] ROW_SCF  = 3'd6;
	localparam logic [2:0] ROW_CCF  = 3'd7;

	// 8-bit operand index
	localparam logic [2:0] R8_B = 3'd0;
	localparam logic [2:0] R8_C = 3'd1;
	localparam logic [2:0] R8_D = 3'd2;
	localparam logic [2:0] R8_E = 3'd3;
	localparam logic [2:0] R8_H = 3'd4;
	localparam logic [2:0] R8_L = 3'd5;
	localparam logic [2:0] R8_MEM_HL = 3'd6;
	localparam logic [2:0] R8_A = 3'd7;

	// 16-bit pair index
	localparam logic [1:0] PAIR_BC = 2'd0;
	localparam logic [1:0] PAIR_DE = 2'd1;
	localparam logic [1:0] PAIR_HL = 2'd2;
	localparam logic [1:0] PAIR_SP = 2'd3;

	localparam int MAX_REPORTS = 200;

	typedef struct packed {
		byte_t  acc;
		flag_t  flags;
		word_t  pair_bc;
		word_t  pair_de;
		word_t  pair_hl;
		word_t  stack_ptr;
		word_t  prog_ctr;
		wkind_t write_kind;
		word_t  write_addr;
		word_t  write_data;
	} exec_result_t;

	byte_t a_q;
	flag_t f_q;
	word_t bc_q, de_q, hl_q, sp_q, pc_q;

	exec_result_t predicted_q[$];
	exec_result_t want, got;

	function automatic word_t pair_of(input logic [1:0] idx);
		case (idx)
			PAIR_BC: return bc_q;
			PAIR_DE: return de_q;
			PAIR_HL: return hl_q;
			default: return sp_q;
		endcase
	endfunction

	task automatic put_pair(input logic [1:0] idx, input word_t v);
		case (idx)
			PAIR_BC: bc_q = v;
			PAIR_DE: de_q = v;
			PAIR_HL: hl_q = v;
			default: sp_q = v;
		endcase
	endtask

	function automatic byte_t r8_of(input logic [2:0] idx, input byte_t mem);
		case (idx)
			R8_B: return bc_q[15:8];
			R8_C: return bc_q[7:0];
			R8_D: return de_q[15:8];
			R8_E: return de_q[7:0];
			R8_H: return hl_q[15:8];
			R8_L: return hl_q[7:0];
			R8_MEM_HL: return mem;
			default: return a_q;
		endcase
	endfunction

	task automatic put_r8(input logic [2:0] idx, input byte_t v);
		case (idx)
			R8_B: bc_q[15:8] = v;
			R8_C: bc_q[7:0] = v;
			R8_D: de_q[15:8] = v;
			R8_E: de_q[7:0] = v;
			R8_H: hl_q[15:8] = v;
			R8_L: hl_q[7:0] = v;
			R8_A: a_q = v;
			default: ;
		endcase
	endtask

	// run one instruction on the local register copy
	task automatic execute_instr(input cmd_t op, input word_t imm, input byte_t mem,
			output exec_result_t r);
		logic [2:0]  row, col;
		word_t       pc, wa, wd, rr;
		wkind_t      wk;
		flag_t       f;
		logic        take, cin, c;
		logic [16:0] sum;
		logic [12:0] low_sum;
		byte_t       old, nv, a;

		row = op[5:3];
		col = op[2:0];
		pc  = pc_q + 16'd1;
		wk  = WK_NONE;
		wa  = '0;
		wd  = '0;
		f   = f_q;
		case (col)
			COL_CTRL: begin
				if (row == ROW_LD_A16_SP) begin
					pc = pc + 16'd2;
					wk = WK_TWO;
					wa = imm;
					wd = sp_q;
				end else if (row == ROW_STOP) begin
					pc = pc + 16'd1;
				end else if (row != ROW_NOP) begin
					pc = pc + 16'd1;
					case (row)
						ROW_JR_NZ: take = !f[FLAG_Z];
						ROW_JR_Z:  take = f[FLAG_Z];
						ROW_JR_NC: take = !f[FLAG_C];
						ROW_JR_C:  take = f[FLAG_C];
						default:   take = 1'b1;
					endcase
					if (take)
						pc = pc + {{8{imm[7]}}, imm[7:0]};
				end
			end
			COL_PAIR16: begin
				if (!row[0]) begin
					pc = pc + 16'd2;
					put_pair(row[2:1], imm);
				end else begin
					rr      = pair_of(row[2:1]);
					sum     = {1'b0, hl_q} + {1'b0, rr};
					low_sum = {1'b0, hl_q[11:0]} + {1'b0, rr[11:0]};
					f[FLAG_N] = 1'b0;
					f[FLAG_H] = low_sum[12];
					f[FLAG_C] = sum[16];
					hl_q = sum[15:0];
				end
			end
			COL_LD_IND: begin
				case (row[2:1])
					PAIR_BC: rr = bc_q;
					PAIR_DE: rr = de_q;
					default: rr = hl_q;
				endcase
				if (!row[0]) begin
					wk = WK_ONE;
					wa = rr;
					wd = {8'h00, a_q};
				end else begin
					a_q = mem;
				end
				if (row[2:1] == PAIR_HL)
					hl_q = hl_q + 16'd1;
				else if (row[2:1] == PAIR_SP)
					hl_q = hl_q - 16'd1;
			end
			COL_INCDEC16: begin
				if (!row[0])
					put_pair(row[2:1], pair_of(row[2:1]) + 16'd1);
				else
					put_pair(row[2:1], pair_of(row[2:1]) - 16'd1);
			end
			COL_INC8, COL_DEC8: begin
				old = r8_of(row, mem);
				f[FLAG_Z] = 1'b0;
				f[FLAG_N] = 1'b0;
				f[FLAG_H] = 1'b0;
				if (col == COL_INC8) begin
					nv = old + 8'd1;
					f[FLAG_H] = (old[3:0] == 4'hF);
				end else begin
					nv = old - 8'd1;
					f[FLAG_N] = 1'b1;
					f[FLAG_H] = (old[3:0] == 4'h0);
				end
				f[FLAG_Z] = (nv == 8'h00);
				if (row == R8_MEM_HL) begin
					wk = WK_ONE;
					wa = hl_q;
					wd = {8'h00, nv};
				end else begin
					put_r8(row, nv);
				end
			end
			COL_LD8_IMM: begin
				pc = pc + 16'd1;
				if (row == R8_MEM_HL) begin
					wk = WK_ONE;
					wa = hl_q;
					wd = {8'h00, imm[7:0]};
				end else begin
					put_r8(row, imm[7:0]);
				end
			end
			default: begin
				a   = a_q;
				cin = f[FLAG_C];
				case (row)
					ROW_RLCA: begin
						f   = {3'b000, a[7]};
						a_q = {a[6:0], a[7]};
					end
					ROW_RRCA: begin
						f   = {3'b000, a[0]};
						a_q = {a[0], a[7:1]};
					end
					ROW_RLA: begin
						f   = {3'b000, a[7]};
						a_q = {a[6:0], cin};
					end
					ROW_RRA: begin
						f   = {3'b000, a[0]};
						a_q = {cin, a[7:1]};
					end
					ROW_DAA: begin
						c = cin;
						if (!f[FLAG_N]) begin
							if (c || a > 8'h99) begin
								a = a + 8'h60;
								c = 1'b1;
							end
							if (f[FLAG_H] || a[3:0] > 4'd9)
								a = a + 8'h06;
						end else begin
							if (c)
								a = a - 8'h60;
							if (f[FLAG_H])
								a = a - 8'h06;
						end
						a_q = a;
						f[FLAG_Z] = (a == 8'h00);
						f[FLAG_H] = 1'b0;
						f[FLAG_C] = c;
					end
					ROW_CPL: begin
						a_q = ~a;
						f[FLAG_N] = 1'b1;
						f[FLAG_H] = 1'b1;
					end
					ROW_SCF: begin
						f[FLAG_N] = 1'b0;
						f[FLAG_H] = 1'b0;
						f[FLAG_C] = 1'b1;
					end
					default: begin
						f[FLAG_N] = 1'b0;
						f[FLAG_H] = 1'b0;
						f[FLAG_C] = !cin;
					end
				endcase
			end
		endcase
		f_q  = f;
		pc_q = pc;
		r = '{acc: a_q, flags: f_q, pair_bc: bc_q, pair_de: de_q, pair_hl: hl_q,
			stack_ptr: sp_q, prog_ctr: pc_q, write_kind: wk, write_addr: wa,
			write_data: wd};
	endtask

	task automatic check_field(input string name, input word_t exp_v, input word_t act_v);
		if (exp_v !== act_v) begin
			if (fail_count < MAX_REPORTS)
				$display("%0t ns: %s expected %h, actual %h", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count       = 0;
		awaiting_results = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q  = '0;
			f_q  = '0;
			bc_q = '0;
			de_q = '0;
			hl_q = '0;
			sp_q = '0;
			pc_q = '0;
			predicted_q.delete();
			awaiting_results = 0;
		end else begin
			if (result.valid && result.ready) begin
				got = '{acc: result.acc, flags: result.flags, pair_bc: result.pair_bc,
					pair_de: result.pair_de, pair_hl: result.pair_hl,
					stack_ptr: result.stack_ptr, prog_ctr: result.prog_ctr,
					write_kind: result.write_kind, write_addr: result.write_addr,
					write_data: result.write_data};
				if (predicted_q.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("%0t ns: unexpected result, expected none, actual %h",
							$time, got);
					fail_count++;
				end else begin
					want = predicted_q.pop_front();
					check_field("acc", word_t'(want.acc), word_t'(got.acc));
					check_field("flags", word_t'(want.flags), word_t'(got.flags));
					check_field("pair_bc", want.pair_bc, got.pair_bc);
					check_field("pair_de", want.pair_de, got.pair_de);
					check_field("pair_hl", want.pair_hl, got.pair_hl);
					check_field("stack_ptr", want.stack_ptr, got.stack_ptr);
					check_field("prog_ctr", want.prog_ctr, got.prog_ctr);
					check_field("write_kind", word_t'(want.write_kind),
						word_t'(got.write_kind));
					check_field("write_addr", want.write_addr, got.write_addr);
					check_field("write_data", want.write_data, got.write_data);
				end
			end
			if (instr.valid && instr.ready) begin
				execute_instr(instr.cmd, instr.immediate, instr.mem_in, want);
				predicted_q.push_back(want);
			end
			awaiting_results = predicted_q.size();
		end
	end

endmodule

// ----- dv/tb_cpu_block0_instruction_execute.sv -----
// top-level testbench for the block-zero execute unit: stimulus, flow control and verdict
module tb_cpu_block0_instruction_execute;
	timeunit 1ns;
	timeprecision 1ps;

	import cb0ie_pkg::*;

	// opcodes used by name in the directed and sequence stimulus
	localparam cmd_t OP_NOP        = 6'h00;
	localparam cmd_t OP_LD_BC_D16  = 6'h01;
	localparam cmd_t OP_INC_B      = 6'h04;
	localparam cmd_t OP_DEC_B      = 6'h05;
	localparam cmd_t OP_RLCA       = 6'h07;
	localparam cmd_t OP_LD_A16_SP  = 6'h08;
	localparam cmd_t OP_ADD_HL_BC  = 6'h09;
	localparam cmd_t OP_DEC_BC     = 6'h0B;
	localparam cmd_t OP_STOP       = 6'h10;
	localparam cmd_t OP_JR         = 6'h18;
	localparam cmd_t OP_RRA        = 6'h1F;
	localparam cmd_t OP_JR_NZ      = 6'h20;
	localparam cmd_t OP_LD_HL_D16  = 6'h21;
	localparam cmd_t OP_LD_HLI_A   = 6'h22;
	localparam cmd_t OP_INC_HL     = 6'h23;
	localparam cmd_t OP_DAA        = 6'h27;
	localparam cmd_t OP_ADD_HL_HL  = 6'h29;
	localparam cmd_t OP_CPL        = 6'h2F;
	localparam cmd_t OP_LD_SP_D16  = 6'h31;
	localparam cmd_t OP_INC_MHL    = 6'h34;
	localparam cmd_t OP_DEC_MHL    = 6'h35;
	localparam cmd_t OP_LD_MHL_D8  = 6'h36;
	localparam cmd_t OP_SCF        = 6'h37;
	localparam cmd_t OP_JR_C       = 6'h38;
	localparam cmd_t OP_ADD_HL_SP  = 6'h39;
	localparam cmd_t OP_LD_A_HLD   = 6'h3A;
	localparam cmd_t OP_INC_A      = 6'h3C;
	localparam cmd_t OP_DEC_A      = 6'h3D;
	localparam cmd_t OP_LD_A_D8    = 6'h3E;
	localparam cmd_t OP_CCF        = 6'h3F;

	// distance between neighboring pair rows and jump rows in the opcode map
	localparam cmd_t PAIR_STEP = 6'h10;
	localparam cmd_t ROW_STEP  = 6'h08;

	localparam int PHASE_REQUESTS = 400;

	logic clk = 1'b0;
	logic arst_n;

	int gap_pct;      // chance in percent, per draw, that the sender idles before a request
	int stall_pct;    // chance in percent, per draw, that the receiver holds off
	int req_count;
	int req_target;
	int fail_count;
	int awaiting_results;

	cb0ie_in_if  instr_ch ();
	cb0ie_out_if result_ch ();

	cpu_block0_instruction_execute i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.instr  (instr_ch),
		.result (result_ch)
	);

	cb0ie_exec_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.instr            (instr_ch),
		.result           (result_ch),
		.fail_count       (fail_count),
		.awaiting_results (awaiting_results)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure, redrawn every falling edge
	always @(negedge clk)
		result_ch.ready <= ($urandom_range(99) >= stall_pct);

	// hard stop in case the pipeline hangs
	initial begin
		#5000000;
		$display("cpu_block0_instruction_execute: mismatch");
		$finish;
	end

	// operand values skewed toward the corners
	function automatic word_t rand_word();
		case ($urandom_range(7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'h8000;
			3: return 16'h7FFF;
			default: return word_t'($urandom_range(16'hFFFF));
		endcase
	endfunction

	// present one request and hold it until the block takes it
	// entered and left just after a falling edge
	task automatic send_instr(input cmd_t op, input word_t imm, input byte_t mem);
		while ($urandom_range(99) < gap_pct) begin
			instr_ch.valid <= 1'b0;
			@(negedge clk);
		end
		instr_ch.valid     <= 1'b1;
		instr_ch.cmd       <= op;
		instr_ch.immediate <= imm;
		instr_ch.mem_in    <= mem;
		do
			@(posedge clk);
		while (!instr_ch.ready);
		@(negedge clk);
		req_count++;
	endtask

	// short instruction runs that exercise flag-dependent paths, or single random opcodes, with random content
	task automatic send_random_run();
		int   pick;
		cmd_t flag_op;

		pick = $urandom_range(99);
		if (pick < 15) begin
			// load A, maybe nudge it or the flags, then decimal adjust
			send_instr(OP_LD_A_D8, rand_word(), byte_t'(rand_word()));
			case ($urandom_range(4))
				0: send_instr(OP_INC_A, rand_word(), byte_t'(rand_word()));
				1: send_instr(OP_DEC_A, rand_word(), byte_t'(rand_word()));
				2: send_instr(OP_SCF, rand_word(), byte_t'(rand_word()));
				3: send_instr(OP_CPL, rand_word(), byte_t'(rand_word()));
				default: ;
			endcase
			send_instr(OP_DAA, rand_word(), byte_t'(rand_word()));
		end else if (pick < 25) begin
			// 16-bit add on a freshly loaded HL
			send_instr(OP_LD_HL_D16, rand_word(), byte_t'(rand_word()));
			send_instr(cmd_t'(OP_ADD_HL_BC + PAIR_STEP * $urandom_range(3)), rand_word(),
				byte_t'(rand_word()));
		end else if (pick < 35) begin
			// set up Z or C, then a relative jump of any kind
			case ($urandom_range(3))
				0: flag_op = OP_SCF;
				1: flag_op = OP_CCF;
				2: flag_op = OP_INC_A;
				default: flag_op = OP_DEC_A;
			endcase
			send_instr(flag_op, rand_word(), byte_t'(rand_word()));
			send_instr(cmd_t'(OP_JR + ROW_STEP * $urandom_range(4)), rand_word(),
				byte_t'(rand_word()));
		end else begin
			send_instr(cmd_t'($urandom_range(63)), rand_word(), byte_t'(rand_word()));
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		instr_ch.valid     = 1'b0;
		instr_ch.cmd       = OP_NOP;
		instr_ch.immediate = '0;
		instr_ch.mem_in    = '0;
		result_ch.ready    = 1'b0;
		gap_pct            = 0;
		stall_pct          = 0;
		req_count          = 0;
		req_target         = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed corners, no idling
		send_instr(OP_NOP, 16'hFFFF, 8'hFF);            // operands ignored
		send_instr(OP_LD_SP_D16, 16'hFFFF, 8'h00);
		send_instr(OP_LD_A16_SP, 16'hFFFF, 8'h00);      // two-byte store at top of memory
		send_instr(OP_LD_HL_D16, 16'h0FFF, 8'h00);
		send_instr(OP_ADD_HL_HL, 16'h0000, 8'h00);      // half carry out of bit 11
		send_instr(OP_LD_HL_D16, 16'hFFFF, 8'h00);
		send_instr(OP_ADD_HL_SP, 16'h0000, 8'h00);      // both carries
		send_instr(OP_INC_HL, 16'h0000, 8'h00);
		send_instr(OP_LD_HLI_A, 16'h0000, 8'h00);       // HL wraps upward
		send_instr(OP_DEC_BC, 16'h0000, 8'h00);         // BC wraps downward
		send_instr(OP_INC_B, 16'h0000, 8'h00);          // ff to 00, Z and H
		send_instr(OP_DEC_B, 16'h0000, 8'h00);          // 00 to ff, N and H
		send_instr(OP_INC_MHL, 16'h0000, 8'hFF);        // memory increment wraps
		send_instr(OP_DEC_MHL, 16'h0000, 8'h00);
		send_instr(OP_LD_MHL_D8, 16'hFFAB, 8'h00);      // only the low byte is stored
		send_instr(OP_LD_A_D8, 16'h009A, 8'h00);
		send_instr(OP_DAA, 16'h0000, 8'h00);            // subtract-side adjust with carry set
		send_instr(OP_LD_A_D8, 16'h0015, 8'h00);
		send_instr(OP_DEC_A, 16'h0000, 8'h00);
		send_instr(OP_CPL, 16'h0000, 8'h00);
		send_instr(OP_DAA, 16'h0000, 8'h00);            // subtract-side adjust
		send_instr(OP_SCF, 16'h0000, 8'h00);
		send_instr(OP_CCF, 16'h0000, 8'h00);
		send_instr(OP_RLCA, 16'h0000, 8'h00);
		send_instr(OP_RRA, 16'h0000, 8'h00);
		send_instr(OP_JR, 16'h0080, 8'h00);             // most negative offset
		send_instr(OP_JR_NZ, 16'h007F, 8'h00);          // most positive offset
		send_instr(OP_JR_C, 16'h0000, 8'h00);
		send_instr(OP_STOP, 16'h0000, 8'h00);
		send_instr(OP_LD_BC_D16, 16'h8001, 8'h00);
		send_instr(OP_LD_A_HLD, 16'h0000, 8'h00);       // HL wraps below zero

		// random phases: free flow, sender gaps, receiver stalls, both
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 47; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 47; end
				default: begin gap_pct = 25; stall_pct = 25; end
			endcase
			req_target = req_count + PHASE_REQUESTS;
			while (req_count < req_target)
				send_random_run();
		end

		// drain: stop sending, open the receiver and let the pipeline empty
		instr_ch.valid <= 1'b0;
		stall_pct = 0;
		while (awaiting_results != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		if (fail_count == 0)
			$display("cpu_block0_instruction_execute: match");
		else
			$display("cpu_block0_instruction_execute: mismatch");
		$finish;
	end

endmodule
